// ----- design/tbts_pkg.sv -----
`default_nettype none
package tbts_pkg;
    localparam int NUM_TIMERS_DEF = 16;

    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_CREATE  = 3'd1;
    localparam logic [2:0] ACT_START   = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_UPDATE  = 3'd4;
    localparam logic [2:0] ACT_REMOVE  = 3'd5;
    localparam logic [2:0] ACT_SERVICE = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PERIOD = 2'd1;
    localparam logic [1:0] ST_NO_SLOT    = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC  = 2'd3;

    localparam logic [31:0] NO_ALARM = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_SCAN,
        S_FINISH,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item
        logic single;   // run a single-slot action
        logic scan_clr; // reset scan index
        logic scan_en;  // process one slot of the scan
        logic finish;   // form the result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_scan;  // action needs a full scan
        logic scan_last;
    } sts_t;
endpackage
`default_nettype wire

// ----- design/tbts_ctrl.sv -----
`default_nettype none
module tbts_ctrl (
    input  wire  logic          aclk,
    input  wire  logic          aresetn,
    input  wire  logic          in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire  logic          out_ready,
    input  wire  tbts_pkg::sts_t sts,
    output tbts_pkg::cmd_t      cmd
);
    import tbts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SINGLE;
            S_SINGLE: state_next = sts.is_scan ? S_SCAN : S_FINISH;
            S_SCAN:   if (sts.scan_last) state_next = S_FINISH;
            S_FINISH: state_next = S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SINGLE: begin
                cmd.single   = 1'b1;
                cmd.scan_clr = 1'b1;
            end
            S_SCAN:   cmd.scan_en = 1'b1;
            S_FINISH: cmd.finish = 1'b1;
            S_OUT:    out_valid = 1'b1;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

// ----- design/tbts_dp.sv -----
`default_nettype none
module tbts_dp #(
    parameter int NUM_TIMERS = tbts_pkg::NUM_TIMERS_DEF
) (
    input  wire  logic           aclk,
    input  wire  logic           aresetn,
    input  wire  tbts_pkg::cmd_t cmd,
    output tbts_pkg::sts_t       sts,
    input  wire  logic [2:0]     in_action,
    input  wire  logic [3:0]     in_slot,
    input  wire  logic [63:0]    in_now_ms,
    input  wire  logic [31:0]    in_period_ms,
    input  wire  logic           in_repeating,
    output logic [1:0]           status,
    output logic [3:0]           new_slot,
    output logic [31:0]          alarm_period,
    output logic                 wake,
    output logic [15:0]          fire_mask
);
    import tbts_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MW = (NUM_TIMERS > 16) ? NUM_TIMERS : 16;

    logic [NUM_TIMERS-1:0] used_reg, rep_reg, run_reg, exp_reg;
    logic [63:0] expiry_mem [NUM_TIMERS];
    logic [31:0] period_mem [NUM_TIMERS];
    logic [31:0] last_alarm_reg;

    logic [2:0]  act_reg;
    logic [3:0]  slot_reg;
    logic [63:0] now_reg;
    logic [31:0] per_reg;
    logic        rep_in_reg;

    logic [IW-1:0]  idx_reg;
    logic [MW-1:0]  mask_reg;
    logic [31:0]    least_reg;
    logic [1:0]     st_reg;
    logic [3:0]     nslot_reg;
    logic [31:0]    alarm_reg;
    logic [1:0]     st_next;
    logic [3:0]     nslot_next;
    logic [31:0]    alarm_next;

    logic [1:0]  status_reg;
    logic [3:0]  new_slot_reg;
    logic [31:0] alarm_out_reg;
    logic        wake_reg;
    logic [15:0] fire_reg;

    // single-slot decode
    logic          sel_ok;
    logic [IW-1:0] sel;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [NUM_TIMERS-1:0] used_after_rm;
    logic [63:0]   scan_exp;
    logic [31:0]   scan_per;

    assign sel    = in_slot_idx(slot_reg);
    assign sel_ok = ({28'd0, slot_reg} < 32'(NUM_TIMERS)) && used_reg[sel];

    function automatic logic [IW-1:0] in_slot_idx(input logic [3:0] s);
        logic [IW+3:0] w;
        w = {{IW{1'b0}}, s};
        return w[IW-1:0];
    endfunction

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb begin
        used_after_rm      = used_reg;
        used_after_rm[sel] = 1'b0;
    end

    // status, new slot and alarm period of a single-slot action
    always_comb begin
        st_next    = ST_OK;
        nslot_next = 4'd0;
        alarm_next = last_alarm_reg;
        case (act_reg)
            ACT_CREATE: begin
                if (per_reg == 32'd0) begin
                    st_next = ST_BAD_PERIOD;
                end else if (!free_found) begin
                    st_next = ST_NO_SLOT;
                end else begin
                    nslot_next = 4'({{4{1'b0}}, free_idx});
                    if (per_reg < last_alarm_reg) alarm_next = per_reg;
                end
            end
            ACT_START, ACT_STOP: begin
                if (!sel_ok) st_next = ST_NOT_ALLOC;
            end
            ACT_UPDATE: begin
                if (!sel_ok) begin
                    st_next = ST_NOT_ALLOC;
                end else if (per_reg == 32'd0) begin
                    st_next = ST_BAD_PERIOD;
                end else if (per_reg != period_mem[sel] && per_reg < last_alarm_reg) begin
                    alarm_next = per_reg;
                end
            end
            ACT_REMOVE: begin
                if (!sel_ok) begin
                    st_next = ST_NOT_ALLOC;
                end else if (used_after_rm == '0) begin
                    alarm_next = NO_ALARM;
                end
            end
            default: ;
        endcase
    end

    assign scan_exp = expiry_mem[idx_reg];
    assign scan_per = period_mem[idx_reg];

    assign sts.is_scan   = (act_reg == ACT_TICK) || (act_reg == ACT_SERVICE);
    assign sts.scan_last = (idx_reg == IW'(NUM_TIMERS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg    <= in_action;
            slot_reg   <= in_slot;
            now_reg    <= in_now_ms;
            per_reg    <= in_period_ms;
            rep_in_reg <= in_repeating;
        end
        if (cmd.scan_clr) begin
            idx_reg   <= '0;
            mask_reg  <= '0;
            least_reg <= NO_ALARM;
        end
        if (cmd.scan_en) begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.finish) begin
            status_reg   <= st_reg;
            new_slot_reg <= nslot_reg;
            if (act_reg == ACT_TICK) begin
                alarm_out_reg <= least_reg;
                wake_reg      <= |mask_reg;
                fire_reg      <= mask_reg[15:0];
            end else begin
                alarm_out_reg <= alarm_reg;
                wake_reg      <= 1'b0;
                fire_reg      <= (act_reg == ACT_SERVICE) ? mask_reg[15:0] : 16'd0;
            end
        end
        if (cmd.single) begin
            st_reg    <= st_next;
            nslot_reg <= nslot_next;
            alarm_reg <= alarm_next;
            case (act_reg)
                ACT_CREATE: begin
                    if (per_reg != 32'd0 && free_found) begin
                        expiry_mem[free_idx] <= '0;
                        period_mem[free_idx] <= per_reg;
                    end
                end
                ACT_START: begin
                    if (sel_ok) expiry_mem[sel] <= now_reg + {32'd0, period_mem[sel]};
                end
                ACT_STOP: begin
                    if (sel_ok) expiry_mem[sel] <= '0;
                end
                ACT_UPDATE: begin
                    if (sel_ok && per_reg != 32'd0 && per_reg != period_mem[sel])
                        period_mem[sel] <= per_reg;
                end
                ACT_REMOVE: begin
                    if (sel_ok) expiry_mem[sel] <= '0;
                end
                default: ;
            endcase
        end
        if (cmd.scan_en && act_reg == ACT_TICK) begin
            if (used_reg[idx_reg] && run_reg[idx_reg] && !exp_reg[idx_reg]
                    && now_reg >= scan_exp) begin
                mask_reg[idx_reg] <= 1'b1;
                if (rep_reg[idx_reg] && scan_per < least_reg) least_reg <= scan_per;
            end
        end
        if (cmd.scan_en && act_reg == ACT_SERVICE) begin
            if (used_reg[idx_reg] && exp_reg[idx_reg]) begin
                mask_reg[idx_reg] <= 1'b1;
                if (rep_reg[idx_reg]) expiry_mem[idx_reg] <= now_reg + {32'd0, scan_per};
            end
        end
    end

    // control marks, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            rep_reg        <= '0;
            run_reg        <= '0;
            exp_reg        <= '0;
            last_alarm_reg <= NO_ALARM;
        end else begin
            if (cmd.single) begin
                case (act_reg)
                    ACT_CREATE: begin
                        if (per_reg != 32'd0 && free_found) begin
                            used_reg[free_idx] <= 1'b1;
                            rep_reg[free_idx]  <= rep_in_reg;
                            run_reg[free_idx]  <= 1'b0;
                            exp_reg[free_idx]  <= 1'b0;
                        end
                    end
                    ACT_START: begin
                        if (sel_ok) begin
                            run_reg[sel] <= 1'b1;
                            exp_reg[sel] <= 1'b0;
                        end
                    end
                    ACT_STOP: begin
                        if (sel_ok) begin
                            run_reg[sel] <= 1'b0;
                            exp_reg[sel] <= 1'b1;
                        end
                    end
                    ACT_UPDATE: begin
                        if (sel_ok && per_reg != 32'd0) rep_reg[sel] <= rep_in_reg;
                    end
                    ACT_REMOVE: begin
                        if (sel_ok) begin
                            used_reg[sel] <= 1'b0;
                            rep_reg[sel]  <= 1'b0;
                            run_reg[sel]  <= 1'b0;
                            exp_reg[sel]  <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.scan_en && act_reg == ACT_TICK) begin
                if (used_reg[idx_reg] && run_reg[idx_reg] && !exp_reg[idx_reg]
                        && now_reg >= scan_exp) begin
                    exp_reg[idx_reg] <= 1'b1;
                    if (!rep_reg[idx_reg]) run_reg[idx_reg] <= 1'b0;
                end
            end
            if (cmd.scan_en && act_reg == ACT_SERVICE) begin
                if (used_reg[idx_reg] && exp_reg[idx_reg]) exp_reg[idx_reg] <= 1'b0;
            end
            if (cmd.finish && act_reg == ACT_TICK) last_alarm_reg <= least_reg;
        end
    end

    assign status       = status_reg;
    assign new_slot     = new_slot_reg;
    assign alarm_period = alarm_out_reg;
    assign wake         = wake_reg;
    assign fire_mask    = fire_reg;
endmodule
`default_nettype wire

// ----- design/timer_bank_tick_scan.sv -----
// Timer bank with a slot-by-slot scan.
// Input stream s_axis: one item per action (tick, create, start, stop, update,
// remove, service) with slot, time and period. Output stream m_axis: exactly
// one result item per input item, carrying status, allocated slot, alarm
// period, wake flag and fire mask.
// Create, start, stop, update and remove pass through the single-slot step, the
// finish step and the output state; tick and service also walk every slot, one
// per cycle, through the expiry and period memories at the scan index.
// A new item is taken in the cycle after its result is taken, so items do not
// overlap.
// Reset (aresetn low, synchronous) frees all slots, clears all marks and sets
// the stored alarm period to all ones; no clearing pass is needed.
// While m_axis_tready is low the result holds and no new item is taken.
`default_nettype none
module timer_bank_tick_scan #(
    parameter int NUM_TIMERS = tbts_pkg::NUM_TIMERS_DEF
) (
    input  wire  logic          aclk,
    input  wire  logic          aresetn,
    input  wire  logic          s_axis_tvalid,
    output logic                s_axis_tready,
    // action[2:0], slot[6:3], now_ms[70:7], period_ms[102:71], repeating[103]
    input  wire  logic [103:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire  logic          m_axis_tready,
    // status[1:0], new_slot[5:2], alarm_period[37:6], wake[38], fire_mask[54:39]
    output logic [55:0]         m_axis_tdata
);
    import tbts_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [1:0]  status;
    logic [3:0]  new_slot;
    logic [31:0] alarm_period;
    logic        wake;
    logic [15:0] fire_mask;

    tbts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tbts_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_action    (s_axis_tdata[2:0]),
        .in_slot      (s_axis_tdata[6:3]),
        .in_now_ms    (s_axis_tdata[70:7]),
        .in_period_ms (s_axis_tdata[102:71]),
        .in_repeating (s_axis_tdata[103]),
        .status       (status),
        .new_slot     (new_slot),
        .alarm_period (alarm_period),
        .wake         (wake),
        .fire_mask    (fire_mask)
    );

    assign m_axis_tdata = {1'b0, fire_mask, wake, alarm_period, new_slot, status};
endmodule
`default_nettype wire
